### hdl/rau_pkg.sv
package rau_pkg;

    // operand width actually used from each 32-bit field
    localparam int NUM_W   = 32;
    localparam int FIELD_W = 32;
    localparam int PROD_W  = 2 * NUM_W;
    localparam int ALU_W   = PROD_W + 1;
    localparam int SHIFT_W = $clog2(PROD_W);
    localparam int CNT_W   = $clog2(NUM_W);
    localparam int CMD_W   = 3;
    localparam int ERR_W   = 2;

    localparam logic [CMD_W-1:0] CMD_ADD = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SUB = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MUL = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DIV = 3'd3;
    localparam logic [CMD_W-1:0] CMD_GT  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_EQ  = 3'd5;

    localparam logic [ERR_W-1:0] ERR_OK   = 2'd0;
    localparam logic [ERR_W-1:0] ERR_DIV0 = 2'd1;
    localparam logic [ERR_W-1:0] ERR_ZDEN = 2'd2;
    localparam logic [ERR_W-1:0] ERR_OVF  = 2'd3;

    localparam logic ALU_ADD = 1'b0;
    localparam logic ALU_SUB = 1'b1;

    typedef struct packed {
        logic [ALU_W-1:0] res;
        logic             lt;   // a < b, valid for subtract
        logic             eq;
    } t_alu_res;

endpackage

### hdl/rational_arith_unit.sv
// Rational arithmetic unit: add, subtract, multiply, divide, greater-than and
// equal on two signed fractions (signed numerator over unsigned denominator).
// Input channel: i_valid / o_stall with i_command and the four operand fields.
// A word is taken when i_valid is high and o_stall low. o_stall stays high
// from the word's acceptance until its result has been handed to the output
// register, so one word is in work at a time.
// Output channel: o_valid / i_stall with o_res_num, o_res_den, o_truth and
// o_error. The result sits in an output register; while the receiver stalls,
// the block still accepts and works on the next word and holds that result
// internally until the output register frees.
// Multiply and divide take three passes through one 32x32 multiplier, a binary
// GCD on the 64-bit magnitude and denominator (common trailing-zero shifts, then
// subtract/shift steps), then two restoring divisions of NUM_W steps each on the
// shared subtractor; add and subtract also pass through an order and a combine
// step after the products. Unused commands and errors found at the input go
// straight to the finish state, compares end after the order step, and zero
// results skip the GCD and the divisions.
// Reset (synchronous, active low) returns the sequencer to idle and empties
// the output register; no stored state survives between words.
module rational_arith_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [rau_pkg::CMD_W-1:0]           i_command,
    input  logic signed [rau_pkg::FIELD_W-1:0]  i_a_num,
    input  logic [rau_pkg::FIELD_W-1:0]         i_a_den,
    input  logic signed [rau_pkg::FIELD_W-1:0]  i_b_num,
    input  logic [rau_pkg::FIELD_W-1:0]         i_b_den,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [rau_pkg::FIELD_W-1:0]  o_res_num,
    output logic [rau_pkg::FIELD_W-1:0]         o_res_den,
    output logic                                o_truth,
    output logic [rau_pkg::ERR_W-1:0]           o_error
);

    localparam int W = rau_pkg::NUM_W;
    localparam int P = rau_pkg::PROD_W;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CHECK  = 4'd1;
    localparam logic [3:0] S_MUL0   = 4'd2;
    localparam logic [3:0] S_MUL1   = 4'd3;
    localparam logic [3:0] S_MUL2   = 4'd4;
    localparam logic [3:0] S_ORDER  = 4'd5;
    localparam logic [3:0] S_COMB   = 4'd6;
    localparam logic [3:0] S_GINIT  = 4'd7;
    localparam logic [3:0] S_TZ     = 4'd8;
    localparam logic [3:0] S_GCD    = 4'd9;
    localparam logic [3:0] S_PRE    = 4'd10;
    localparam logic [3:0] S_DIV    = 4'd11;
    localparam logic [3:0] S_FINAL  = 4'd12;
    localparam logic [3:0] S_FINISH = 4'd13;

    // control
    logic [3:0] r_state, n_state;
    logic       r_ovalid, n_ovalid;

    // operands
    logic [rau_pkg::CMD_W-1:0] r_cmd, n_cmd;
    logic signed [W-1:0]       r_an, n_an, r_bn, n_bn;
    logic [W-1:0]              r_ad, n_ad, r_bd, n_bd;
    logic [W-1:0]              r_am, n_am, r_bm, n_bm;   // magnitudes
    logic                      r_an_neg, n_an_neg, r_bn_neg, n_bn_neg;
    logic                      r_sb, n_sb;               // effective sign of b term
    logic                      r_neg, n_neg;             // result sign
    logic                      r_swap, n_swap;

    // products, GCD and division
    logic [P-1:0]                  r_m1, n_m1, r_m2, n_m2, r_den, n_den;
    logic [P-1:0]                  r_u, n_u, r_v, n_v, r_g, n_g, r_rem, n_rem;
    logic [rau_pkg::SHIFT_W-1:0]   r_k, n_k;
    logic                          r_lane, n_lane;
    logic [W-1:0]                  r_dvd, n_dvd, r_q, n_q, r_qm, n_qm;
    logic [rau_pkg::CNT_W-1:0]     r_cnt, n_cnt;

    // staged result and output register
    logic [rau_pkg::FIELD_W-1:0] r_rn, n_rn, r_rd, n_rd;
    logic                        r_rt, n_rt;
    logic [rau_pkg::ERR_W-1:0]   r_re, n_re;
    logic [rau_pkg::FIELD_W-1:0] r_o_num, n_o_num, r_o_den, n_o_den;
    logic                        r_o_truth, n_o_truth;
    logic [rau_pkg::ERR_W-1:0]   r_o_err, n_o_err;

    // shared units
    logic [W-1:0]              mul_x, mul_y;
    logic [P-1:0]              prod;
    logic [rau_pkg::ALU_W-1:0] alu_a, alu_b;
    logic                      alu_op;
    rau_pkg::t_alu_res         alu;

    logic [P-1:0]              div_src;
    logic [rau_pkg::ALU_W-1:0] trial;
    logic [W-1:0]              q_next;
    logic signed [W-1:0]       fin_num;
    logic                      fin_ovf;
    logic                      cmp_gt, cmp_eq;
    logic                      is_cmp, cmd_ok, zden, out_free;

    assign o_stall   = (r_state != S_IDLE);
    assign o_valid   = r_ovalid;
    assign o_res_num = r_o_num;
    assign o_res_den = r_o_den;
    assign o_truth   = r_o_truth;
    assign o_error   = r_o_err;

    assign out_free = !r_ovalid || !i_stall;

    assign is_cmp = (r_cmd == rau_pkg::CMD_GT) || (r_cmd == rau_pkg::CMD_EQ);
    assign cmd_ok = (r_cmd <= rau_pkg::CMD_EQ);
    assign zden   = ((r_an != '0) && (r_ad == '0)) || ((r_bn != '0) && (r_bd == '0));

    // one multiplier, one product per cycle
    always_comb begin
        mul_x = r_am;
        mul_y = r_bd;
        case (r_state)
            S_MUL0: begin
                mul_x = r_am;
                mul_y = (r_cmd == rau_pkg::CMD_MUL) ? r_bm : r_bd;
            end
            S_MUL1: begin
                mul_x = r_bm;
                mul_y = r_ad;
            end
            S_MUL2: begin
                mul_x = r_ad;
                mul_y = (r_cmd == rau_pkg::CMD_DIV) ? r_bm : r_bd;
            end
            default: begin
                mul_x = r_am;
                mul_y = r_bd;
            end
        endcase
    end

    assign prod = P'(mul_x) * P'(mul_y);

    // division lane: magnitude first, then denominator
    assign div_src = r_lane ? r_den : r_m1;
    assign trial   = {r_rem, r_dvd[W-1]};
    assign q_next  = {r_q[W-2:0], ~alu.lt};

    // shared subtractor operand select
    always_comb begin
        alu_a  = {1'b0, r_m1};
        alu_b  = {1'b0, r_m2};
        alu_op = rau_pkg::ALU_SUB;
        case (r_state)
            S_COMB: begin
                if (r_an_neg == r_sb) begin
                    alu_op = rau_pkg::ALU_ADD;
                end else if (r_swap) begin
                    alu_a = {1'b0, r_m2};
                    alu_b = {1'b0, r_m1};
                end
            end
            S_GCD: begin
                alu_a = {1'b0, r_u};
                alu_b = {1'b0, r_v};
            end
            S_PRE: begin
                alu_a = rau_pkg::ALU_W'(div_src[P-1:W]);
                alu_b = {1'b0, r_g};
            end
            S_DIV: begin
                alu_a = trial;
                alu_b = {1'b0, r_g};
            end
            default: begin
                alu_a = {1'b0, r_m1};
                alu_b = {1'b0, r_m2};
            end
        endcase
    end

    rau_alu u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_op  (alu_op),
        .o_res (alu)
    );

    // sign-magnitude compare of the two cross products
    always_comb begin
        if (!r_an_neg && r_bn_neg) begin
            cmp_gt = 1'b1;
        end else if (r_an_neg && !r_bn_neg) begin
            cmp_gt = 1'b0;
        end else if (r_an_neg) begin
            cmp_gt = alu.lt;
        end else begin
            cmp_gt = !alu.lt && !alu.eq;
        end
    end

    assign cmp_eq = (r_an_neg == r_bn_neg) && alu.eq;

    // a negative result may reach -2^(W-1)
    assign fin_ovf = r_neg ? (r_qm[W-1] && (r_qm[W-2:0] != '0)) : r_qm[W-1];
    assign fin_num = r_neg ? -r_qm : r_qm;

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_an      = r_an;
        n_bn      = r_bn;
        n_ad      = r_ad;
        n_bd      = r_bd;
        n_am      = r_am;
        n_bm      = r_bm;
        n_an_neg  = r_an_neg;
        n_bn_neg  = r_bn_neg;
        n_sb      = r_sb;
        n_neg     = r_neg;
        n_swap    = r_swap;
        n_m1      = r_m1;
        n_m2      = r_m2;
        n_den     = r_den;
        n_u       = r_u;
        n_v       = r_v;
        n_g       = r_g;
        n_k       = r_k;
        n_lane    = r_lane;
        n_rem     = r_rem;
        n_dvd     = r_dvd;
        n_q       = r_q;
        n_qm      = r_qm;
        n_cnt     = r_cnt;
        n_rn      = r_rn;
        n_rd      = r_rd;
        n_rt      = r_rt;
        n_re      = r_re;
        n_o_num   = r_o_num;
        n_o_den   = r_o_den;
        n_o_truth = r_o_truth;
        n_o_err   = r_o_err;
        n_ovalid  = r_ovalid && i_stall;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_cmd   = i_command;
                    n_an    = i_a_num[W-1:0];
                    n_ad    = i_a_den[W-1:0];
                    n_bn    = i_b_num[W-1:0];
                    n_bd    = i_b_den[W-1:0];
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_rn = '0;
                n_rd = '0;
                n_rt = 1'b0;
                n_re = rau_pkg::ERR_OK;
                if (!cmd_ok) begin
                    n_state = S_FINISH;
                end else if (zden) begin
                    n_re    = rau_pkg::ERR_ZDEN;
                    n_state = S_FINISH;
                end else if ((r_cmd == rau_pkg::CMD_DIV) && (r_bn == '0)) begin
                    n_re    = rau_pkg::ERR_DIV0;
                    n_state = S_FINISH;
                end else begin
                    // zero operand counts as 0/1
                    if (r_an == '0) begin
                        n_ad = W'(1);
                    end
                    if (r_bn == '0) begin
                        n_bd = W'(1);
                    end
                    n_an_neg = r_an[W-1];
                    n_bn_neg = r_bn[W-1];
                    n_am     = r_an[W-1] ? -r_an : r_an;
                    n_bm     = r_bn[W-1] ? -r_bn : r_bn;
                    n_sb     = (r_cmd == rau_pkg::CMD_SUB) ?
                               (!r_bn[W-1] && (r_bn != '0)) : r_bn[W-1];
                    n_state  = S_MUL0;
                end
            end
            S_MUL0: begin
                n_m1    = prod;
                n_state = S_MUL1;
            end
            S_MUL1: begin
                n_m2    = prod;
                n_state = S_MUL2;
            end
            S_MUL2: begin
                n_den = prod;
                case (r_cmd) inside
                    rau_pkg::CMD_MUL, rau_pkg::CMD_DIV: begin
                        n_neg   = r_an_neg ^ r_bn_neg;
                        n_state = S_GINIT;
                    end
                    default: begin
                        n_state = S_ORDER;
                    end
                endcase
            end
            S_ORDER: begin
                n_swap = alu.lt;
                if (is_cmp) begin
                    n_rt    = (r_cmd == rau_pkg::CMD_GT) ? cmp_gt : cmp_eq;
                    n_state = S_FINISH;
                end else begin
                    n_state = S_COMB;
                end
            end
            S_COMB: begin
                n_m1    = alu.res[P-1:0];
                n_neg   = (r_an_neg != r_sb) && r_swap ? r_sb : r_an_neg;
                n_state = S_GINIT;
            end
            S_GINIT: begin
                if (r_m1 == '0) begin
                    n_state = S_FINISH;
                end else begin
                    n_u     = r_m1;
                    n_v     = r_den;
                    n_k     = '0;
                    n_state = S_TZ;
                end
            end
            S_TZ: begin
                // strip the common power of two
                if (r_u[0] || r_v[0]) begin
                    n_state = S_GCD;
                end else begin
                    n_u = r_u >> 1;
                    n_v = r_v >> 1;
                    n_k = r_k + 1'b1;
                end
            end
            S_GCD: begin
                if (alu.eq) begin
                    n_g     = r_u << r_k;
                    n_lane  = 1'b0;
                    n_state = S_PRE;
                end else if (!r_u[0]) begin
                    n_u = r_u >> 1;
                end else if (!r_v[0]) begin
                    n_v = r_v >> 1;
                end else if (alu.lt) begin
                    n_u = r_v;
                    n_v = r_u;
                end else begin
                    n_u = alu.res[P-1:0] >> 1;
                end
            end
            S_PRE: begin
                // quotient of W+1 bits or more cannot fit
                if (!alu.lt) begin
                    n_re    = rau_pkg::ERR_OVF;
                    n_state = S_FINISH;
                end else begin
                    n_rem   = P'(div_src[P-1:W]);
                    n_dvd   = div_src[W-1:0];
                    n_q     = '0;
                    n_cnt   = rau_pkg::CNT_W'(W - 1);
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_rem = alu.lt ? trial[P-1:0] : alu.res[P-1:0];
                n_q   = q_next;
                n_dvd = r_dvd << 1;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    if (!r_lane) begin
                        n_qm    = q_next;
                        n_lane  = 1'b1;
                        n_state = S_PRE;
                    end else begin
                        n_state = S_FINAL;
                    end
                end
            end
            S_FINAL: begin
                if (fin_ovf) begin
                    n_re = rau_pkg::ERR_OVF;
                end else begin
                    n_rn = rau_pkg::FIELD_W'(fin_num);
                    n_rd = rau_pkg::FIELD_W'(r_q);
                end
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (out_free) begin
                    n_o_num   = r_rn;
                    n_o_den   = r_rd;
                    n_o_truth = r_rt;
                    n_o_err   = r_re;
                    n_ovalid  = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_an      <= n_an;
        r_bn      <= n_bn;
        r_ad      <= n_ad;
        r_bd      <= n_bd;
        r_am      <= n_am;
        r_bm      <= n_bm;
        r_an_neg  <= n_an_neg;
        r_bn_neg  <= n_bn_neg;
        r_sb      <= n_sb;
        r_neg     <= n_neg;
        r_swap    <= n_swap;
        r_m1      <= n_m1;
        r_m2      <= n_m2;
        r_den     <= n_den;
        r_u       <= n_u;
        r_v       <= n_v;
        r_g       <= n_g;
        r_k       <= n_k;
        r_lane    <= n_lane;
        r_rem     <= n_rem;
        r_dvd     <= n_dvd;
        r_q       <= n_q;
        r_qm      <= n_qm;
        r_cnt     <= n_cnt;
        r_rn      <= n_rn;
        r_rd      <= n_rd;
        r_rt      <= n_rt;
        r_re      <= n_re;
        r_o_num   <= n_o_num;
        r_o_den   <= n_o_den;
        r_o_truth <= n_o_truth;
        r_o_err   <= n_o_err;
    end

    // GCD operands never reach zero
    a_gcd_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GCD) |-> ((r_u != '0) && (r_v != '0)))
        else $error("gcd operand became zero");

    // after the common twos are stripped, one operand stays odd
    a_gcd_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GCD) |-> (r_u[0] || r_v[0]))
        else $error("gcd lost its odd operand");

    // restoring division keeps the partial remainder below the divisor
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_g))
        else $error("division remainder out of range");

    // a finished word moves to the output as soon as the register frees
    a_finish_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FINISH) && out_free) |=> (o_valid && (r_state == S_IDLE)))
        else $error("finished word not loaded to output");

endmodule

### hdl/rau_alu.sv
module rau_alu (
    input  logic [rau_pkg::ALU_W-1:0] i_a,
    input  logic [rau_pkg::ALU_W-1:0] i_b,
    input  logic                      i_op,
    output rau_pkg::t_alu_res         o_res
);

    logic                      sub;
    logic [rau_pkg::ALU_W-1:0] b_opnd;
    logic [rau_pkg::ALU_W:0]   sum;

    assign sub    = (i_op == rau_pkg::ALU_SUB);
    assign b_opnd = sub ? ~i_b : i_b;
    assign sum    = {1'b0, i_a} + {1'b0, b_opnd} + {{rau_pkg::ALU_W{1'b0}}, sub};

    // no carry out of a subtract means a borrow
    assign o_res.res = sum[rau_pkg::ALU_W-1:0];
    assign o_res.lt  = sub & ~sum[rau_pkg::ALU_W];
    assign o_res.eq  = (i_a == i_b);

endmodule
